// File: hdl/hcbd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hcbd_pkg;

  typedef enum logic [2:0] {
    PH_DIGITS = 3'd0,
    PH_REST   = 3'd1,
    PH_OVF    = 3'd2,
    PH_DATA   = 3'd3,
    PH_DCR    = 3'd4,
    PH_DLF    = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    ST_RUN   = 3'd0,
    ST_DONE  = 3'd1,
    ST_HDR   = 3'd2,
    ST_SIZE  = 3'd3,
    ST_CHUNK = 3'd4,
    ST_BIG   = 3'd5
  } status_e;

  // One decoded word as it leaves the decoder core
  typedef struct packed {
    status_e    status;
    logic       out_valid;
    logic [7:0] out_byte;
  } res_t;

  localparam logic [7:0]  CHAR_CR        = 8'h0D;
  localparam logic [7:0]  CHAR_LF        = 8'h0A;
  localparam logic [31:0] MAX_BODY_RESET = 32'd4194304;

  // Bit 4 flags a hex digit, bits 3:0 hold its value
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hdl/hcbd_core.sv
`timescale 1ns / 1ps
`default_nettype none

module hcbd_core #(
  parameter int SIZE_BITS = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire logic [7:0]    in_byte_i,
  input  wire logic          start_i,
  input  wire logic          last_i,
  input  wire logic [31:0]   max_body_i,
  output hcbd_pkg::res_t     res_o
);

  localparam int CMP_W = (SIZE_BITS > 32) ? SIZE_BITS : 32;

  hcbd_pkg::phase_e       phase_q, phase_d, phase_c;
  hcbd_pkg::status_e      status_q, status_d, status_c;
  logic                   pcr_q, pcr_d, pcr_c;
  logic                   seen_q, seen_d, seen_c;
  logic [SIZE_BITS-1:0]   acc_q, acc_d, acc_c;
  logic [31:0]            rem_q, rem_d, rem_c;
  logic [31:0]            cnt_q, cnt_d, cnt_c;
  logic [4:0]             hex;
  logic [CMP_W-1:0]       acc_ext;
  logic [31:0]            headroom;

  // Start of body wipes the state before the word is handled
  always_comb begin
    phase_c  = phase_q;
    status_c = status_q;
    pcr_c    = pcr_q;
    seen_c   = seen_q;
    acc_c    = acc_q;
    rem_c    = rem_q;
    cnt_c    = cnt_q;
    if (start_i) begin
      phase_c  = hcbd_pkg::PH_DIGITS;
      status_c = hcbd_pkg::ST_RUN;
      pcr_c    = 1'b0;
      seen_c   = 1'b0;
      acc_c    = '0;
      rem_c    = '0;
      cnt_c    = '0;
    end
  end

  assign hex      = hcbd_pkg::hex_digit(in_byte_i);
  assign acc_ext  = CMP_W'(acc_c);
  assign headroom = max_body_i - cnt_c;

  // Next state
  always_comb begin
    phase_d  = phase_c;
    status_d = status_c;
    pcr_d    = pcr_c;
    seen_d   = seen_c;
    acc_d    = acc_c;
    rem_d    = rem_c;
    cnt_d    = cnt_c;
    if (status_c == hcbd_pkg::ST_RUN) begin
      unique case (phase_c) inside
        hcbd_pkg::PH_DIGITS, hcbd_pkg::PH_REST, hcbd_pkg::PH_OVF: begin
          if (in_byte_i == hcbd_pkg::CHAR_LF && pcr_c) begin
            if (!seen_c || phase_c == hcbd_pkg::PH_OVF) begin
              status_d = hcbd_pkg::ST_SIZE;
            end else if (acc_c == '0) begin
              status_d = hcbd_pkg::ST_DONE;
            end else if (cnt_c > max_body_i || acc_ext > CMP_W'(headroom)) begin
              status_d = hcbd_pkg::ST_BIG;
            end else begin
              rem_d   = acc_ext[31:0];
              phase_d = hcbd_pkg::PH_DATA;
            end
          end else begin
            pcr_d = (in_byte_i == hcbd_pkg::CHAR_CR);
            if (phase_c == hcbd_pkg::PH_DIGITS) begin
              if (!hex[4]) begin
                phase_d = hcbd_pkg::PH_REST;
              end else begin
                seen_d = 1'b1;
                // another digit overflows once the top nibble is in use
                if (|acc_c[SIZE_BITS-1 -: 4]) begin
                  phase_d = hcbd_pkg::PH_OVF;
                end else begin
                  acc_d = {acc_c[SIZE_BITS-5:0], hex[3:0]};
                end
              end
            end
          end
        end
        hcbd_pkg::PH_DATA: begin
          cnt_d = cnt_c + 32'd1;
          rem_d = rem_c - 32'd1;
          if (rem_c == 32'd1) begin
            phase_d = hcbd_pkg::PH_DCR;
          end
        end
        hcbd_pkg::PH_DCR: begin
          if (in_byte_i == hcbd_pkg::CHAR_CR) begin
            phase_d = hcbd_pkg::PH_DLF;
          end else begin
            status_d = hcbd_pkg::ST_CHUNK;
          end
        end
        hcbd_pkg::PH_DLF: begin
          if (in_byte_i == hcbd_pkg::CHAR_LF) begin
            phase_d = hcbd_pkg::PH_DIGITS;
            pcr_d   = 1'b0;
            seen_d  = 1'b0;
            acc_d   = '0;
          end else begin
            status_d = hcbd_pkg::ST_CHUNK;
          end
        end
        default: ;
      endcase
      if (last_i && status_d == hcbd_pkg::ST_RUN) begin
        if (phase_d == hcbd_pkg::PH_DIGITS || phase_d == hcbd_pkg::PH_REST ||
            phase_d == hcbd_pkg::PH_OVF) begin
          status_d = hcbd_pkg::ST_HDR;
        end else begin
          status_d = hcbd_pkg::ST_CHUNK;
        end
      end
    end
  end

  // Result word
  always_comb begin
    res_o.status    = status_d;
    res_o.out_valid = (status_c == hcbd_pkg::ST_RUN) && (phase_c == hcbd_pkg::PH_DATA);
    res_o.out_byte  = res_o.out_valid ? in_byte_i : 8'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= hcbd_pkg::PH_DIGITS;
      status_q <= hcbd_pkg::ST_RUN;
      pcr_q    <= 1'b0;
      seen_q   <= 1'b0;
      acc_q    <= '0;
      rem_q    <= '0;
      cnt_q    <= '0;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      status_q <= status_d;
      pcr_q    <= pcr_d;
      seen_q   <= seen_d;
      acc_q    <= acc_d;
      rem_q    <= rem_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/http_chunked_body_decoder_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Payload
// s_axis    in         tdata[7:0] in_byte, tuser start_of_body, tlast end_of_input
// m_axis    out        tdata[7:0] out_byte, tuser[0] out_valid, tuser[3:1] status
// apb       in         register 0 at 0x0: max_body_bytes (32 bit)
//
// One word per clock unless the output stalls; each input word yields one output word.
// The state update and the result sit between the input handshake and one output register.
// A word is taken whenever the output register is empty or drained in the same cycle.
// Reset clears the decoder state and sets max_body_bytes to 4194304.
module http_chunked_body_decoder_top #(
  parameter int SIZE_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // in_byte
  input  wire logic        s_axis_tuser,   // start_of_body
  input  wire logic        s_axis_tlast,   // end_of_input
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // out_byte
  output logic [3:0]       m_axis_tuser,   // out_valid, status[2:0]
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam logic [2:0] ADDR_MAX_BODY = 3'd0;

  logic           accept;
  logic [31:0]    max_body_q;
  logic           ovalid_q;
  hcbd_pkg::res_t res, res_q;

  assign pready        = 1'b1;
  assign s_axis_tready = !ovalid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_body_q <= hcbd_pkg::MAX_BODY_RESET;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_MAX_BODY) begin
      max_body_q <= pwdata;
    end
  end

  assign prdata = (paddr == ADDR_MAX_BODY) ? max_body_q : 32'd0;

  hcbd_core #(
    .SIZE_BITS(SIZE_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_byte_i  (s_axis_tdata),
    .start_i    (s_axis_tuser),
    .last_i     (s_axis_tlast),
    .max_body_i (max_body_q),
    .res_o      (res)
  );

  // Hold the word until the sink takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (accept) begin
      ovalid_q <= 1'b1;
    end else if (m_axis_tready) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = res_q.out_byte;
  assign m_axis_tuser  = {res_q.status, res_q.out_valid};

endmodule

`default_nettype wire

// File: verif/http_chunked_body_decoder_top_tb.sv
`timescale 1ns / 1ps

module http_chunked_body_decoder_top_tb;

  localparam int          SIZE_W       = 32;
  localparam logic [63:0] SIZE_MAX     = (64'd1 << SIZE_W) - 64'd1;
  localparam logic [2:0]  REG_MAX_BODY = 3'd0;
  localparam string       CRLF         = "\015\012";

  typedef struct packed {
    logic [7:0] data;
    logic       sob;
    logic       eoi;
  } enc_item_t;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'd0;  // in_byte
  logic        s_axis_tuser  = 1'b0;  // start_of_body
  logic        s_axis_tlast  = 1'b0;  // end_of_input
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;          // out_byte
  logic [3:0]  m_axis_tuser;          // out_valid, status[2:0]
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = 3'd0;
  logic [31:0] pwdata        = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  enc_item_t       encoded_fifo[$];
  hcbd_pkg::res_t  decoded_fifo[$];
  int        bytes_queued = 0;
  int        bytes_taken  = 0;
  int        err_count    = 0;
  bit        in_taken     = 1'b0;
  bit        out_taken    = 1'b0;
  bit        no_idle      = 1'b0;
  bit        hold_req     = 1'b0;
  bit        rcv_hold     = 1'b0;
  int        send_wait    = 0;
  int        rcv_wait     = 0;

  // Decoder state as the predictor sees it
  logic [31:0]        max_body;
  hcbd_pkg::phase_e   dec_phase;
  logic               cr_seen;
  logic               have_digit;
  logic [63:0]        size_acc;
  logic [31:0]        remaining;
  logic [31:0]        decoded_total;
  hcbd_pkg::status_e  verdict;

  http_chunked_body_decoder_top #(
    .SIZE_BITS(SIZE_W)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  function automatic void clear_decoder();
    dec_phase     = hcbd_pkg::PH_DIGITS;
    cr_seen       = 1'b0;
    have_digit    = 1'b0;
    size_acc      = 64'd0;
    remaining     = 32'd0;
    decoded_total = 32'd0;
    verdict       = hcbd_pkg::ST_RUN;
  endfunction

  function automatic hcbd_pkg::res_t decode_byte(input logic [7:0] b, input logic sob,
                                                 input logic eoi);
    hcbd_pkg::res_t r;
    int             dig;
    logic [63:0]    lim;
    r = '0;
    if (sob) clear_decoder();
    if (verdict == hcbd_pkg::ST_RUN) begin
      if (dec_phase == hcbd_pkg::PH_DIGITS || dec_phase == hcbd_pkg::PH_REST ||
          dec_phase == hcbd_pkg::PH_OVF) begin
        if (b == hcbd_pkg::CHAR_LF && cr_seen) begin
          // size line complete: validate, then end the body or open the chunk
          if (!have_digit || dec_phase == hcbd_pkg::PH_OVF) begin
            verdict = hcbd_pkg::ST_SIZE;
          end else if (size_acc == 64'd0) begin
            verdict = hcbd_pkg::ST_DONE;
          end else if (decoded_total > max_body ||
                       size_acc > 64'(max_body - decoded_total)) begin
            verdict = hcbd_pkg::ST_BIG;
          end else begin
            remaining = size_acc[31:0];
            dec_phase = hcbd_pkg::PH_DATA;
          end
        end else begin
          cr_seen = (b == hcbd_pkg::CHAR_CR);
          if (dec_phase == hcbd_pkg::PH_DIGITS) begin
            if (b >= "0" && b <= "9") dig = b - "0";
            else if (b >= "a" && b <= "f") dig = b - "a" + 10;
            else if (b >= "A" && b <= "F") dig = b - "A" + 10;
            else dig = -1;
            if (dig < 0) begin
              dec_phase = hcbd_pkg::PH_REST;
            end else begin
              have_digit = 1'b1;
              lim = (SIZE_MAX - 64'(dig)) / 64'd16;
              if (size_acc > lim) dec_phase = hcbd_pkg::PH_OVF;
              else size_acc = size_acc * 64'd16 + 64'(dig);
            end
          end
        end
      end else if (dec_phase == hcbd_pkg::PH_DATA) begin
        r.out_valid = 1'b1;
        r.out_byte  = b;
        decoded_total++;
        remaining--;
        if (remaining == 32'd0) dec_phase = hcbd_pkg::PH_DCR;
      end else if (dec_phase == hcbd_pkg::PH_DCR) begin
        if (b == hcbd_pkg::CHAR_CR) dec_phase = hcbd_pkg::PH_DLF;
        else verdict = hcbd_pkg::ST_CHUNK;
      end else begin
        if (b == hcbd_pkg::CHAR_LF) begin
          dec_phase  = hcbd_pkg::PH_DIGITS;
          cr_seen    = 1'b0;
          have_digit = 1'b0;
          size_acc   = 64'd0;
        end else begin
          verdict = hcbd_pkg::ST_CHUNK;
        end
      end
      if (eoi && verdict == hcbd_pkg::ST_RUN) begin
        verdict = (dec_phase == hcbd_pkg::PH_DATA || dec_phase == hcbd_pkg::PH_DCR ||
                   dec_phase == hcbd_pkg::PH_DLF) ? hcbd_pkg::ST_CHUNK : hcbd_pkg::ST_HDR;
      end
    end
    r.status = verdict;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    err_count++;
    $display("%0t: %s: got 0x%0h, want 0x%0h", $time, what, got, want);
  endtask

  // Accept input words into the predictor, check output words in order
  always @(posedge clk_i) begin : monitor
    hcbd_pkg::res_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        out_taken = 1'b1;
        if (decoded_fifo.size() == 0) begin
          report_mismatch("output word with none pending", int'(m_axis_tdata), 0);
        end else begin
          want = decoded_fifo.pop_front();
          if (m_axis_tdata != want.out_byte)
            report_mismatch("out_byte", int'(m_axis_tdata), int'(want.out_byte));
          if (m_axis_tuser[0] != want.out_valid)
            report_mismatch("out_valid", int'(m_axis_tuser[0]), int'(want.out_valid));
          if (m_axis_tuser[3:1] != want.status)
            report_mismatch("status", int'(m_axis_tuser[3:1]), int'(want.status));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        decoded_fifo.push_back(decode_byte(s_axis_tdata, s_axis_tuser, s_axis_tlast));
        bytes_taken++;
        in_taken = 1'b1;
      end
    end
  end

  // Offer the next word after its own random gap (none when no_idle is set); hold until taken
  always @(negedge clk_i) begin : driver
    enc_item_t cur;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      in_taken = 1'b0;
      if (send_wait > 0) begin
        send_wait--;
        s_axis_tvalid <= 1'b0;
      end else if (encoded_fifo.size() != 0) begin
        cur = encoded_fifo.pop_front();
        s_axis_tdata  <= cur.data;
        s_axis_tuser  <= cur.sob;
        s_axis_tlast  <= cur.eoi;
        s_axis_tvalid <= 1'b1;
        send_wait = no_idle ? 0 : $urandom_range(0, 7);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin : receiver
    if (out_taken) begin
      out_taken = 1'b0;
      rcv_wait  = no_idle ? 0 : $urandom_range(0, 7);
    end
    if (rcv_hold || rcv_wait > 0) begin
      m_axis_tready <= 1'b0;
      if (!rcv_hold) rcv_wait--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Long receiver hold-off so the decoder backs up into its input
  initial begin
    while (!hold_req) @(posedge clk_i);
    @(posedge clk_i);
    rcv_hold = 1'b1;
    repeat (200) @(posedge clk_i);
    rcv_hold = 1'b0;
  end

  initial begin
    #2000000;
    $display("[http_chunked_body_decoder_top] ERROR");
    $finish;
  end

  task automatic push_item(input logic [7:0] b, input logic sob, input logic eoi);
    encoded_fifo.push_back('{data: b, sob: sob, eoi: eoi});
    bytes_queued++;
  endtask

  task automatic push_text(input string s, input bit sob_first, input bit eoi_last);
    for (int i = 0; i < s.len(); i++)
      push_item(s[i], sob_first && i == 0, eoi_last && i == s.len() - 1);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
    if (n < 4'd10) return 8'("0" + n);
    return upper ? 8'("A" + n - 4'd10) : 8'("a" + n - 4'd10);
  endfunction

  task automatic add_size_line(ref logic [7:0] enc[$], input logic [31:0] value);
    int top;
    bit upper;
    upper = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 3) == 0) enc.push_back("0");
    top = 7;
    while (top > 0 && value[top*4 +: 4] == 4'd0) top--;
    for (int i = top; i >= 0; i--) enc.push_back(hex_char(value[i*4 +: 4], upper));
    case ($urandom_range(0, 7))
      0: begin
        enc.push_back(";");
        repeat ($urandom_range(0, 4)) enc.push_back(8'($urandom));
      end
      1: begin
        // bare CR inside the size line
        enc.push_back(hcbd_pkg::CHAR_CR);
        enc.push_back("x");
      end
      2: enc.push_back(" ");
      default: ;
    endcase
    enc.push_back(hcbd_pkg::CHAR_CR);
    enc.push_back(hcbd_pkg::CHAR_LF);
  endtask

  // One encoded body, mostly well formed, sometimes broken or noise
  task automatic gen_body();
    logic [7:0] enc[$];
    int         kind;
    int         len;
    int         cut;
    bit         eoi_at_end;
    kind = $urandom_range(0, 19);
    if (kind == 18) begin
      repeat ($urandom_range(1, 8)) enc.push_back(8'($urandom));
    end else begin
      if (kind == 13) begin
        enc.push_back(hcbd_pkg::CHAR_CR);
        enc.push_back(hcbd_pkg::CHAR_LF);
      end else if (kind == 14) begin
        // nine digits: above the size range
        enc.push_back("1");
        repeat (8) enc.push_back(hex_char(4'($urandom), 1'($urandom)));
        enc.push_back(hcbd_pkg::CHAR_CR);
        enc.push_back(hcbd_pkg::CHAR_LF);
      end else if (kind == 19) begin
        add_size_line(enc, 32'hFFFF_FFFF);
        repeat (3) enc.push_back(8'($urandom));
      end
      repeat ($urandom_range(0, 3)) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
        add_size_line(enc, 32'(len));
        repeat (len) enc.push_back(8'($urandom));
        enc.push_back(hcbd_pkg::CHAR_CR);
        enc.push_back(hcbd_pkg::CHAR_LF);
      end
      add_size_line(enc, 32'd0);
      if ($urandom_range(0, 3) == 0) begin
        enc.push_back("T");
        enc.push_back(":");
        enc.push_back("1");
        enc.push_back(hcbd_pkg::CHAR_CR);
        enc.push_back(hcbd_pkg::CHAR_LF);
      end
      enc.push_back(hcbd_pkg::CHAR_CR);
      enc.push_back(hcbd_pkg::CHAR_LF);
    end
    if (kind == 15) enc[$urandom_range(0, enc.size() - 1)] = 8'($urandom);
    if (kind == 16 && enc.size() > 1) enc.delete($urandom_range(0, enc.size() - 1));
    cut = (kind == 17) ? $urandom_range(1, enc.size()) : enc.size();
    eoi_at_end = (kind == 17) || ($urandom_range(0, 1) == 0);
    for (int i = 0; i < cut; i++) begin
      push_item(enc[i],
                (i == 0) ? ($urandom_range(0, 19) != 0) : ($urandom_range(0, 149) == 0),
                (i == cut - 1) ? eoi_at_end : ($urandom_range(0, 149) == 0));
    end
  endtask

  task automatic random_phase(input int goal);
    int first;
    first = bytes_queued;
    while (bytes_queued - first < goal) gen_body();
  endtask

  task automatic wait_idle();
    while (!(encoded_fifo.size() == 0 && bytes_taken == bytes_queued &&
             decoded_fifo.size() == 0)) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_max_body(input logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_MAX_BODY;
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    max_body = value;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    max_body = hcbd_pkg::MAX_BODY_RESET;
    clear_decoder();
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // extension skip, 0xFF payload, completion, byte after completion
    push_text({"1;x", CRLF, "\377", CRLF, "0", CRLF, "z"}, 1'b1, 1'b0);
    // empty size line
    push_text(CRLF, 1'b1, 1'b0);
    // bare CR in size line, 0x00 payload, bad chunk terminator
    push_text({"1\015x", CRLF}, 1'b1, 1'b0);
    push_item(8'h00, 1'b0, 1'b0);
    push_item("x", 1'b0, 1'b0);
    // input ends inside the size line
    push_item("2", 1'b1, 1'b1);
    random_phase(150);
    wait_idle();

    write_max_body(32'hFFFF_FFFF);
    @(posedge clk_i);
    no_idle = 1'b1;
    random_phase(150);
    // leave a body open with 32 bytes decoded
    push_text({"20", CRLF, "abcdefghijklmnopqrstuvwxyzABCDEF", CRLF}, 1'b1, 1'b0);
    wait_idle();
    no_idle = 1'b0;

    // limit now below what the open body already holds
    write_max_body(32'd7);
    @(posedge clk_i);
    push_text({"3", CRLF, "abc"}, 1'b0, 1'b0);
    random_phase(150);
    wait_idle();

    write_max_body(32'd0);
    @(posedge clk_i);
    random_phase(150);
    hold_req = 1'b1;
    wait_idle();

    write_max_body(32'd60);
    @(posedge clk_i);
    random_phase(150);
    wait_idle();

    write_max_body(hcbd_pkg::MAX_BODY_RESET);
    @(posedge clk_i);
    random_phase(150);
    wait_idle();

    repeat (8) @(posedge clk_i);
    if (err_count == 0 && decoded_fifo.size() == 0) begin
      $display("[http_chunked_body_decoder_top] OK");
    end else begin
      $display("[http_chunked_body_decoder_top] ERROR");
    end
    $finish;
  end

endmodule
